// ===== rtl/mhfs_pkg.sv =====
// ----------------------------------------------------------------------------
// mhfs_pkg
// Shared types and constants for the min-heap with filter sweeps.
// ----------------------------------------------------------------------------
package mhfs_pkg;

    localparam int KEY_W   = 16;
    localparam int PAGES_W = 16;
    localparam int YEAR_W  = 12;
    localparam int OP_W    = 2;
    localparam int CNT_OUT_W = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [PAGES_W-1:0] PAGE_LIMIT_RST = 16'd300;
    localparam logic [YEAR_W-1:0]  YEAR_LIMIT_RST = 12'd2000;

    localparam logic [CFG_IDX_W-1:0] REG_PAGE_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_YEAR_LIMIT = 1'b1;

    typedef logic [OP_W-1:0] op_t;
    localparam op_t OP_INSERT     = 2'd0;
    localparam op_t OP_PAGE_SWEEP = 2'd1;
    localparam op_t OP_YEAR_SWEEP = 2'd2;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [PAGES_W-1:0] pages;
        logic [YEAR_W-1:0]  year;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_INS_TEST,
        ST_INS_CMP,
        ST_SW_TEST,
        ST_SW_CHK,
        ST_SW_MOVE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load_item;
        logic pos_from_count;
        logic pos_clear;
        logic pos_inc;
        logic pos_to_parent;
        logic cnt_inc;
        logic cnt_dec;
        logic rd_parent;
        logic rd_pos;
        logic rd_last;
        logic wr_new;
        logic wr_rdata;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic full;
        logic pos_zero;
        logic pos_end;
        logic pos_last;
        logic parent_gt;
        logic drop;
    } sts_t;

endpackage

// ===== rtl/min_heap_with_filter_sweeps_core.sv =====
// ----------------------------------------------------------------------------
// min_heap_with_filter_sweeps_core
// Binary min-heap on a 16-bit key with page-count and year filter sweeps.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; operation selects
// insert (key, pages, year), page-limit sweep or year-limit sweep. Exactly one
// result is shown per command on accepted, count, root_key and empty_res,
// valid during the single cycle in which done is high. The receiver cannot
// stall: it must take the result in that cycle.
// Limit registers are written through cfg_valid/cfg_ready (always ready),
// cfg_index 0 for page_limit and 1 for year_limit; the user must write them
// only while the block is idle, as the block itself does not enforce this.
// An insert sifts up until a compare stops it or the entry reaches the root;
// a full heap or an unused code goes straight to done. A sweep scans the
// entries and ends early when it removes the last entry. busy stays high
// through done, so the next command is taken at the earliest on the edge
// ending the cycle after done.
// After reset the heap is empty, page_limit is 300 and year_limit is 2000;
// commands may be issued in the first cycle after reset.
// ----------------------------------------------------------------------------
module min_heap_with_filter_sweeps_core #(
    parameter int CAPACITY = 128
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    output logic                           done,
    input  logic [mhfs_pkg::OP_W-1:0]      operation,
    input  logic [mhfs_pkg::KEY_W-1:0]     key,
    input  logic [mhfs_pkg::PAGES_W-1:0]   pages,
    input  logic [mhfs_pkg::YEAR_W-1:0]    year,
    output logic                           accepted,
    output logic [mhfs_pkg::CNT_OUT_W-1:0] count,
    output logic [mhfs_pkg::KEY_W-1:0]     root_key,
    output logic                           empty_res,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mhfs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mhfs_pkg::PAGES_W-1:0]   cfg_data
);
    import mhfs_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);

    cmd_t             cmd;
    sts_t             sts;
    logic [CW-1:0]    count_val;
    logic [KEY_W-1:0] root_val;

    assign cfg_ready = 1'b1;

    mhfs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .done     (done),
        .accepted (accepted),
        .cmd      (cmd),
        .sts      (sts)
    );

    mhfs_dp #(
        .CAPACITY (CAPACITY),
        .CW       (CW),
        .AW       (AW)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .operation (operation),
        .key       (key),
        .pages     (pages),
        .year      (year),
        .cfg_we    (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .count_val (count_val),
        .root_val  (root_val)
    );

    assign empty_res = (count_val == '0);
    assign count     = CNT_OUT_W'(count_val);
    assign root_key  = empty_res ? '0 : root_val;

endmodule

// ===== rtl/mhfs_dp.sv =====
// ----------------------------------------------------------------------------
// mhfs_dp
// Datapath: entry memory, count, position, limits and the compare logic.
// ----------------------------------------------------------------------------
module mhfs_dp #(
    parameter int CAPACITY = 128,
    parameter int CW = $clog2(CAPACITY + 1),
    parameter int AW = $clog2(CAPACITY)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mhfs_pkg::cmd_t                 cmd,
    output mhfs_pkg::sts_t                 sts,
    input  logic [mhfs_pkg::OP_W-1:0]      operation,
    input  logic [mhfs_pkg::KEY_W-1:0]     key,
    input  logic [mhfs_pkg::PAGES_W-1:0]   pages,
    input  logic [mhfs_pkg::YEAR_W-1:0]    year,
    input  logic                           cfg_we,
    input  logic [mhfs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mhfs_pkg::PAGES_W-1:0]   cfg_data,
    output logic [CW-1:0]                  count_val,
    output logic [mhfs_pkg::KEY_W-1:0]     root_val
);
    import mhfs_pkg::*;

    entry_t               mem [CAPACITY];
    entry_t               rdata_reg;
    entry_t               item_reg;
    op_t                  op_reg;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        pos_reg;
    logic [KEY_W-1:0]     root_reg;
    logic [PAGES_W-1:0]   page_limit_reg;
    logic [YEAR_W-1:0]    year_limit_reg;

    logic [CW-1:0]        pos_dec;
    logic [CW-1:0]        pos_par;
    logic [CW-1:0]        cnt_dec;
    logic [CW-1:0]        rd_sel;
    logic                 wr_en;
    entry_t               wdata;

    assign pos_dec = pos_reg - CW'(1);
    assign pos_par = {1'b0, pos_dec[CW-1:1]};
    assign cnt_dec = count_reg - CW'(1);

    always_comb
    begin
        priority if (cmd.rd_parent)
        begin
            rd_sel = pos_par;
        end
        else if (cmd.rd_last)
        begin
            rd_sel = cnt_dec;
        end
        else
        begin
            rd_sel = pos_reg;
        end
    end

    assign wr_en = cmd.wr_new | cmd.wr_rdata;
    assign wdata = cmd.wr_new ? item_reg : rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[pos_reg[AW-1:0]] <= wdata;
        end
        if (cmd.rd_parent | cmd.rd_pos | cmd.rd_last)
        begin
            rdata_reg <= mem[rd_sel[AW-1:0]];
        end
        if (cmd.load_item)
        begin
            item_reg <= '{key: key, pages: pages, year: year};
        end
        if (wr_en && (pos_reg == '0))
        begin
            root_reg <= wdata.key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg         <= OP_INSERT;
            count_reg      <= '0;
            pos_reg        <= '0;
            page_limit_reg <= PAGE_LIMIT_RST;
            year_limit_reg <= YEAR_LIMIT_RST;
        end
        else
        begin
            if (cmd.load_item)
            begin
                op_reg <= operation;
            end
            if (cmd.cnt_inc)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (cmd.cnt_dec)
            begin
                count_reg <= cnt_dec;
            end
            priority if (cmd.pos_from_count)
            begin
                pos_reg <= count_reg;
            end
            else if (cmd.pos_clear)
            begin
                pos_reg <= '0;
            end
            else if (cmd.pos_inc)
            begin
                pos_reg <= pos_reg + CW'(1);
            end
            else if (cmd.pos_to_parent)
            begin
                pos_reg <= pos_par;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_PAGE_LIMIT: page_limit_reg <= cfg_data;
                    REG_YEAR_LIMIT: year_limit_reg <= cfg_data[YEAR_W-1:0];
                    default:        page_limit_reg <= page_limit_reg;
                endcase
            end
        end
    end

    always_comb
    begin
        sts.op        = op_reg;
        sts.full      = (count_reg >= CW'(CAPACITY));
        sts.pos_zero  = (pos_reg == '0);
        sts.pos_end   = (pos_reg >= count_reg);
        sts.pos_last  = (pos_reg == cnt_dec);
        sts.parent_gt = (rdata_reg.key > item_reg.key);
        sts.drop      = (op_reg == OP_PAGE_SWEEP) ? (rdata_reg.pages <= page_limit_reg)
                                                  : (rdata_reg.year < year_limit_reg);
    end

    assign count_val = count_reg;
    assign root_val  = root_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("Entry count exceeds capacity.");
    a_inc_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_inc |-> (count_reg < CW'(CAPACITY)))
        else $error("Count incremented on a full heap.");
    a_dec_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_dec |-> (count_reg != '0))
        else $error("Count decremented on an empty heap.");
    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (pos_reg < count_reg))
        else $error("Write outside the occupied slots.");
`endif

endmodule

// ===== rtl/mhfs_ctrl.sv =====
// ----------------------------------------------------------------------------
// mhfs_ctrl
// Controller: sequences insert sift-up and filter sweeps over the datapath.
// ----------------------------------------------------------------------------
module mhfs_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    output logic           done,
    output logic           accepted,
    output mhfs_pkg::cmd_t cmd,
    input  mhfs_pkg::sts_t sts
);
    import mhfs_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accepted_reg;
    logic   accepted_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            accepted_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            accepted_reg <= accepted_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                priority if ((sts.op == OP_INSERT) && !sts.full)
                begin
                    state_next = ST_INS_TEST;
                end
                else if ((sts.op == OP_PAGE_SWEEP) || (sts.op == OP_YEAR_SWEEP))
                begin
                    state_next = ST_SW_TEST;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_INS_TEST:
            begin
                state_next = sts.pos_zero ? ST_DONE : ST_INS_CMP;
            end
            ST_INS_CMP:
            begin
                state_next = sts.parent_gt ? ST_INS_TEST : ST_DONE;
            end
            ST_SW_TEST:
            begin
                state_next = sts.pos_end ? ST_DONE : ST_SW_CHK;
            end
            ST_SW_CHK:
            begin
                priority if (!sts.drop)
                begin
                    state_next = ST_SW_TEST;
                end
                else if (sts.pos_last)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_SW_MOVE;
                end
            end
            ST_SW_MOVE:
            begin
                state_next = ST_SW_CHK;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        accepted_next = accepted_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load_item = start;
            end
            ST_DISPATCH:
            begin
                if (sts.op == OP_INSERT)
                begin
                    accepted_next      = !sts.full;
                    cmd.pos_from_count = !sts.full;
                    cmd.cnt_inc        = !sts.full;
                end
                else if ((sts.op == OP_PAGE_SWEEP) || (sts.op == OP_YEAR_SWEEP))
                begin
                    accepted_next = 1'b1;
                    cmd.pos_clear = 1'b1;
                end
                else
                begin
                    accepted_next = 1'b0;
                end
            end
            ST_INS_TEST:
            begin
                cmd.wr_new    = sts.pos_zero;
                cmd.rd_parent = !sts.pos_zero;
            end
            ST_INS_CMP:
            begin
                cmd.wr_rdata      = sts.parent_gt;
                cmd.pos_to_parent = sts.parent_gt;
                cmd.wr_new        = !sts.parent_gt;
            end
            ST_SW_TEST:
            begin
                cmd.rd_pos = !sts.pos_end;
            end
            ST_SW_CHK:
            begin
                cmd.pos_inc = !sts.drop;
                cmd.cnt_dec = sts.drop;
                cmd.rd_last = sts.drop && !sts.pos_last;
            end
            ST_SW_MOVE:
            begin
                cmd.wr_rdata = 1'b1;
            end
            ST_DONE:
            begin
                cmd = '0;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign busy     = (state_reg != ST_IDLE);
    assign done     = (state_reg == ST_DONE);
    assign accepted = accepted_reg;

`ifndef SYNTH
    a_done_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("Result strobe held longer than one cycle.");
    a_start_to_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == ST_DISPATCH))
        else $error("Accepted command did not reach dispatch.");
    a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.wr_new && cmd.wr_rdata))
        else $error("Two write sources selected at once.");
`endif

endmodule

// ===== verif/tb_min_heap_with_filter_sweeps_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_min_heap_with_filter_sweeps_core
// Self-checking testbench for the min-heap with page and year filter sweeps.
// ----------------------------------------------------------------------------
// A short table of directed commands runs first: the empty heap, unused
// operation codes, field extremes and equal keys. Some rows carry the expected
// result typed in. Random phases follow, each with its own limit settings. One
// phase fills the heap and keeps inserting past capacity. A behavioral copy
// of the heap predicts every result, and each done strobe is checked field by field in order.
// ----------------------------------------------------------------------------
module tb_min_heap_with_filter_sweeps_core;

    import mhfs_pkg::*;

    localparam int  CAPACITY  = 128;
    localparam op_t OP_UNUSED = 2'd3;

    typedef struct packed {
        logic                 accepted;
        logic [CNT_OUT_W-1:0] count;
        logic [KEY_W-1:0]     root_key;
        logic                 empty_res;
    } heap_result_t;

    typedef struct {
        op_t                op;
        logic [KEY_W-1:0]   key;
        logic [PAGES_W-1:0] pages;
        logic [YEAR_W-1:0]  year;
        logic               has_typed;
        heap_result_t       typed_res;
    } heap_cmd_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic                  done;
    logic [OP_W-1:0]       operation = '0;
    logic [KEY_W-1:0]      key = '0;
    logic [PAGES_W-1:0]    pages = '0;
    logic [YEAR_W-1:0]     year = '0;
    logic                  accepted;
    logic [CNT_OUT_W-1:0]  count;
    logic [KEY_W-1:0]      root_key;
    logic                  empty_res;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [PAGES_W-1:0]    cfg_data = '0;

    entry_t             heap_copy [CAPACITY];
    int unsigned        heap_size = 0;
    logic [PAGES_W-1:0] page_limit_copy = PAGE_LIMIT_RST;
    logic [YEAR_W-1:0]  year_limit_copy = YEAR_LIMIT_RST;

    heap_result_t expected_results [$];
    heap_cmd_t    directed_cmds [$];
    int           error_count = 0;
    bit           idle_enabled = 1'b1;

    min_heap_with_filter_sweeps_core #(
        .CAPACITY (CAPACITY)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .done      (done),
        .operation (operation),
        .key       (key),
        .pages     (pages),
        .year      (year),
        .accepted  (accepted),
        .count     (count),
        .root_key  (root_key),
        .empty_res (empty_res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic heap_result_t apply_heap_op(input heap_cmd_t cmd);
        heap_result_t res;
        entry_t       tmp;
        int unsigned  pos;
        int unsigned  up;
        logic         drop;
        res.accepted = 1'b0;
        if (cmd.op == OP_INSERT) begin
            if (heap_size < CAPACITY) begin
                pos = heap_size;
                heap_copy[pos].key   = cmd.key;
                heap_copy[pos].pages = cmd.pages;
                heap_copy[pos].year  = cmd.year;
                heap_size++;
                while (pos > 0) begin
                    up = (pos - 1) / 2;
                    if (heap_copy[up].key > heap_copy[pos].key) begin
                        tmp = heap_copy[pos];
                        heap_copy[pos] = heap_copy[up];
                        heap_copy[up] = tmp;
                        pos = up;
                    end
                    else begin
                        break;
                    end
                end
                res.accepted = 1'b1;
            end
        end
        else if (cmd.op == OP_PAGE_SWEEP || cmd.op == OP_YEAR_SWEEP) begin
            pos = 0;
            while (pos < heap_size) begin
                if (cmd.op == OP_PAGE_SWEEP)
                    drop = (heap_copy[pos].pages <= page_limit_copy);
                else
                    drop = (heap_copy[pos].year < year_limit_copy);
                if (drop) begin
                    heap_copy[pos] = heap_copy[heap_size - 1];
                    heap_size--;
                end
                else begin
                    pos++;
                end
            end
            res.accepted = 1'b1;
        end
        res.count     = heap_size[CNT_OUT_W-1:0];
        res.root_key  = (heap_size > 0) ? heap_copy[0].key : '0;
        res.empty_res = (heap_size == 0);
        return res;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!idle_enabled || r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [KEY_W-1:0] rand_key();
        if ($urandom_range(0, 1) == 0)
            return KEY_W'($urandom_range(0, 15));
        return KEY_W'($urandom_range(0, 65535));
    endfunction

    function automatic logic [PAGES_W-1:0] rand_pages();
        int v;
        if ($urandom_range(0, 2) != 0)
            return PAGES_W'($urandom_range(0, 65535));
        v = int'(page_limit_copy) + int'($urandom_range(0, 4)) - 2;
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return PAGES_W'(v);
    endfunction

    function automatic logic [YEAR_W-1:0] rand_year();
        int v;
        if ($urandom_range(0, 2) != 0)
            return YEAR_W'($urandom_range(0, 4095));
        v = int'(year_limit_copy) + int'($urandom_range(0, 4)) - 2;
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return YEAR_W'(v);
    endfunction

    task automatic send_cmd(input heap_cmd_t cmd);
        heap_result_t predicted;
        int unsigned  gap;
        start     <= 1'b1;
        operation <= cmd.op;
        key       <= cmd.key;
        pages     <= cmd.pages;
        year      <= cmd.year;
        do
            @(posedge clk);
        while (busy);
        predicted = apply_heap_op(cmd);
        expected_results.push_back(cmd.has_typed ? cmd.typed_res : predicted);
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        if (start)
            start <= 1'b0;
        while (expected_results.size() != 0 || busy)
            @(posedge clk);
    endtask

    task automatic write_limit(input logic [CFG_IDX_W-1:0] idx,
                               input logic [PAGES_W-1:0] data);
        repeat ($urandom_range(1, 4)) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_PAGE_LIMIT)
            page_limit_copy = data;
        else
            year_limit_copy = data[YEAR_W-1:0];
    endtask

    always @(posedge clk) begin
        heap_result_t exp_res;
        if (rst_n && done) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result: accepted %0d count %0d root_key %0h",
                         $time, accepted, count, root_key);
                error_count++;
            end
            else begin
                exp_res = expected_results.pop_front();
                if (exp_res.accepted !== accepted) begin
                    $display("%0t: accepted mismatch: expected %0d, actual %0d",
                             $time, exp_res.accepted, accepted);
                    error_count++;
                end
                if (exp_res.count !== count) begin
                    $display("%0t: count mismatch: expected %0d, actual %0d",
                             $time, exp_res.count, count);
                    error_count++;
                end
                if (exp_res.root_key !== root_key) begin
                    $display("%0t: root_key mismatch: expected %0h, actual %0h",
                             $time, exp_res.root_key, root_key);
                    error_count++;
                end
                if (exp_res.empty_res !== empty_res) begin
                    $display("%0t: empty_res mismatch: expected %0d, actual %0d",
                             $time, exp_res.empty_res, empty_res);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #4000000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        heap_cmd_t          cmd;
        int unsigned        phase;
        int unsigned        r;
        logic [PAGES_W-1:0] new_page_limit;
        logic [YEAR_W-1:0]  new_year_limit;

        directed_cmds.push_back('{OP_PAGE_SWEEP, 16'h0, 16'h0, 12'h0, 1'b1,
                                  '{1'b1, 8'd0, 16'h0000, 1'b1}});
        directed_cmds.push_back('{OP_YEAR_SWEEP, 16'hFFFF, 16'hFFFF, 12'hFFF, 1'b1,
                                  '{1'b1, 8'd0, 16'h0000, 1'b1}});
        directed_cmds.push_back('{OP_UNUSED, 16'h1234, 16'h5678, 12'h9AB, 1'b1,
                                  '{1'b0, 8'd0, 16'h0000, 1'b1}});
        directed_cmds.push_back('{OP_INSERT, 16'hFFFF, 16'hFFFF, 12'hFFF, 1'b1,
                                  '{1'b1, 8'd1, 16'hFFFF, 1'b0}});
        directed_cmds.push_back('{OP_INSERT, 16'h0000, 16'h0000, 12'h000, 1'b1,
                                  '{1'b1, 8'd2, 16'h0000, 1'b0}});
        directed_cmds.push_back('{OP_INSERT, 16'h0000, 16'd300, 12'd1999, 1'b1,
                                  '{1'b1, 8'd3, 16'h0000, 1'b0}});
        directed_cmds.push_back('{OP_INSERT, 16'h0005, 16'd301, 12'd2000, 1'b1,
                                  '{1'b1, 8'd4, 16'h0000, 1'b0}});
        directed_cmds.push_back('{OP_INSERT, 16'h0003, 16'd1234, 12'd2500, 1'b1,
                                  '{1'b1, 8'd5, 16'h0000, 1'b0}});
        directed_cmds.push_back('{OP_UNUSED, 16'hFFFF, 16'hFFFF, 12'hFFF, 1'b1,
                                  '{1'b0, 8'd5, 16'h0000, 1'b0}});
        directed_cmds.push_back('{OP_PAGE_SWEEP, 16'hABCD, 16'h0001, 12'h001, 1'b0, '0});
        directed_cmds.push_back('{OP_INSERT, 16'h0002, 16'd10, 12'd1000, 1'b0, '0});
        directed_cmds.push_back('{OP_INSERT, 16'h8000, 16'h5555, 12'hAAA, 1'b0, '0});
        directed_cmds.push_back('{OP_INSERT, 16'h7FFF, 16'hAAAA, 12'h555, 1'b0, '0});
        directed_cmds.push_back('{OP_INSERT, 16'h0002, 16'd299, 12'd2001, 1'b0, '0});
        directed_cmds.push_back('{OP_INSERT, 16'h0001, 16'd5000, 12'd100, 1'b0, '0});
        directed_cmds.push_back('{OP_YEAR_SWEEP, 16'h5A5A, 16'hA5A5, 12'h5A5, 1'b0, '0});
        directed_cmds.push_back('{OP_YEAR_SWEEP, 16'h0, 16'h0, 12'h0, 1'b0, '0});
        directed_cmds.push_back('{OP_INSERT, 16'h0000, 16'd300, 12'd3000, 1'b0, '0});
        directed_cmds.push_back('{OP_PAGE_SWEEP, 16'hFFFF, 16'hFFFF, 12'hFFF, 1'b0, '0});
        directed_cmds.push_back('{OP_PAGE_SWEEP, 16'h0, 16'h0, 12'h0, 1'b0, '0});

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_cmds[i])
            send_cmd(directed_cmds[i]);

        for (phase = 0; phase < 6; phase++) begin
            wait_idle();
            case (phase)
                0: begin
                    new_page_limit = '0;
                    new_year_limit = '0;
                end
                1: begin
                    new_page_limit = '1;
                    new_year_limit = '1;
                end
                3: begin
                    new_page_limit = '1;
                    new_year_limit = YEAR_W'($urandom_range(0, 4095));
                end
                default: begin
                    new_page_limit = PAGES_W'($urandom_range(0, 65535));
                    new_year_limit = YEAR_W'($urandom_range(0, 4095));
                end
            endcase
            write_limit(REG_PAGE_LIMIT, new_page_limit);
            write_limit(REG_YEAR_LIMIT, {4'($urandom_range(0, 15)), new_year_limit});
            idle_enabled = ($urandom_range(0, 3) != 0);
            @(posedge clk);

            if (phase == 3) begin
                cmd = '{OP_PAGE_SWEEP, rand_key(), rand_pages(), rand_year(), 1'b0, '0};
                send_cmd(cmd);
                repeat (CAPACITY + 8) begin
                    cmd = '{OP_INSERT, rand_key(), rand_pages(), rand_year(), 1'b0, '0};
                    send_cmd(cmd);
                end
                cmd = '{OP_UNUSED, rand_key(), rand_pages(), rand_year(), 1'b0, '0};
                send_cmd(cmd);
                cmd = '{OP_YEAR_SWEEP, rand_key(), rand_pages(), rand_year(), 1'b0, '0};
                send_cmd(cmd);
                cmd = '{OP_PAGE_SWEEP, rand_key(), rand_pages(), rand_year(), 1'b0, '0};
                send_cmd(cmd);
            end
            else begin
                repeat (100) begin
                    r = $urandom_range(0, 99);
                    if (r < 84)
                        cmd.op = OP_INSERT;
                    else if (r < 91)
                        cmd.op = OP_PAGE_SWEEP;
                    else if (r < 97)
                        cmd.op = OP_YEAR_SWEEP;
                    else
                        cmd.op = OP_UNUSED;
                    cmd.key       = rand_key();
                    cmd.pages     = rand_pages();
                    cmd.year      = rand_year();
                    cmd.has_typed = 1'b0;
                    cmd.typed_res = '0;
                    send_cmd(cmd);
                end
            end
        end

        wait_idle();
        repeat (40) @(posedge clk);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/mhfs_pkg.sv
rtl/mhfs_dp.sv
rtl/mhfs_ctrl.sv
rtl/min_heap_with_filter_sweeps_core.sv
verif/tb_min_heap_with_filter_sweeps_core.sv
